// ===== hw/rtl/pts_pkg.sv =====
// Shared types, codes and defaults of the phased periodic task scheduler.
// Used by pts_ctrl, pts_dp and the top level; depends on nothing.
`default_nettype none

package pts_pkg;

    localparam int ENTRIES_DEF    = 32;
    localparam int PHASES_DEF     = 8;
    localparam int TAG_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 16;

    // Slot pointers: 6 bits, all ones is the end-of-list mark
    localparam int             PTR_W = 6;
    localparam logic [PTR_W-1:0] NIL = 6'd63;

    // Operation codes
    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_REM_HDL = 2'd1;
    localparam logic [1:0] OP_REM_TAG = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    // Result kinds
    localparam logic [2:0] KIND_INSERTED  = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_REMOVED   = 3'd2;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [2:0] KIND_FIRED     = 3'd4;
    localparam logic [2:0] KIND_DONE      = 3'd5;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  phase;
        logic [15:0] tag;
        logic [15:0] interval;
        logic [15:0] first_count;
        logic [4:0]  handle;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  slot;
        logic [15:0] fired_tag;
        logic [5:0]  removed_count;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_INS_A,
        S_INS_B,
        S_RH_CHK,
        S_FREE_A,
        S_FREE_B,
        S_TW_HEAD,
        S_TW_VISIT,
        S_TK_HEAD,
        S_TK_VISIT,
        S_TK_FIRE,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_START,
        CMD_INS_A,
        CMD_INS_B,
        CMD_FREE_A,
        CMD_FREE_B,
        CMD_HEAD,
        CMD_NEXT_PH,
        CMD_ADV,
        CMD_TICK,
        CMD_FIRE,
        CMD_FINAL
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       ins_ok;
        logic       ph_ok;
        logic       h_ok;
        logic       cur_live;
        logic       match;
        logic       fire_zero;
        logic       ph_last;
        logic       can_emit;
        logic [5:0] rcnt;
    } t_status;

endpackage

`default_nettype wire

// ===== hw/rtl/pts_ctrl.sv =====
// Sequencer of the task scheduler: walks each operation through its steps.
// Depends on pts_pkg; drives commands into pts_dp and reads its status.
`default_nettype none

module pts_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  pts_pkg::t_status  i_status,
    output pts_pkg::t_cmd     o_cmd,
    output logic              o_in_stall,
    output pts_pkg::t_state   o_state
);

    pts_pkg::t_state r_state;
    pts_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pts_pkg::S_IDLE: begin
                if (i_in_valid) n_state = pts_pkg::S_START;
            end
            pts_pkg::S_START: begin
                unique case (i_status.op)
                    pts_pkg::OP_INSERT:
                        n_state = i_status.ins_ok ? pts_pkg::S_INS_A : pts_pkg::S_EMIT;
                    pts_pkg::OP_REM_HDL: n_state = pts_pkg::S_RH_CHK;
                    pts_pkg::OP_REM_TAG: n_state = pts_pkg::S_TW_HEAD;
                    default:
                        n_state = i_status.ph_ok ? pts_pkg::S_TK_HEAD : pts_pkg::S_EMIT;
                endcase
            end
            pts_pkg::S_INS_A:  n_state = pts_pkg::S_INS_B;
            pts_pkg::S_INS_B:  n_state = pts_pkg::S_EMIT;
            pts_pkg::S_RH_CHK: begin
                n_state = i_status.h_ok ? pts_pkg::S_FREE_A : pts_pkg::S_EMIT;
            end
            pts_pkg::S_FREE_A: n_state = pts_pkg::S_FREE_B;
            pts_pkg::S_FREE_B: begin
                n_state = (i_status.op == pts_pkg::OP_REM_TAG) ? pts_pkg::S_TW_VISIT
                                                                : pts_pkg::S_EMIT;
            end
            pts_pkg::S_TW_HEAD: n_state = pts_pkg::S_TW_VISIT;
            pts_pkg::S_TW_VISIT: begin
                if (!i_status.cur_live) begin
                    n_state = i_status.ph_last ? pts_pkg::S_EMIT : pts_pkg::S_TW_HEAD;
                end else if (i_status.match) begin
                    n_state = pts_pkg::S_FREE_A;
                end
            end
            pts_pkg::S_TK_HEAD: n_state = pts_pkg::S_TK_VISIT;
            pts_pkg::S_TK_VISIT: begin
                if (!i_status.cur_live) begin
                    n_state = pts_pkg::S_EMIT;
                end else if (i_status.fire_zero) begin
                    n_state = pts_pkg::S_TK_FIRE;
                end
            end
            pts_pkg::S_TK_FIRE: begin
                if (i_status.can_emit) n_state = pts_pkg::S_TK_VISIT;
            end
            pts_pkg::S_EMIT: begin
                if (i_status.can_emit) n_state = pts_pkg::S_IDLE;
            end
            default: n_state = pts_pkg::S_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd = pts_pkg::CMD_NONE;
        unique case (r_state)
            pts_pkg::S_IDLE: begin
                if (i_in_valid) o_cmd = pts_pkg::CMD_LOAD;
            end
            pts_pkg::S_START:   o_cmd = pts_pkg::CMD_START;
            pts_pkg::S_INS_A:   o_cmd = pts_pkg::CMD_INS_A;
            pts_pkg::S_INS_B:   o_cmd = pts_pkg::CMD_INS_B;
            pts_pkg::S_RH_CHK:  o_cmd = pts_pkg::CMD_NONE;
            pts_pkg::S_FREE_A:  o_cmd = pts_pkg::CMD_FREE_A;
            pts_pkg::S_FREE_B:  o_cmd = pts_pkg::CMD_FREE_B;
            pts_pkg::S_TW_HEAD: o_cmd = pts_pkg::CMD_HEAD;
            pts_pkg::S_TK_HEAD: o_cmd = pts_pkg::CMD_HEAD;
            pts_pkg::S_TW_VISIT: begin
                if (!i_status.cur_live) begin
                    if (!i_status.ph_last) o_cmd = pts_pkg::CMD_NEXT_PH;
                end else if (!i_status.match) begin
                    o_cmd = pts_pkg::CMD_ADV;
                end
            end
            pts_pkg::S_TK_VISIT: begin
                if (i_status.cur_live && !i_status.fire_zero) o_cmd = pts_pkg::CMD_TICK;
            end
            pts_pkg::S_TK_FIRE: begin
                if (i_status.can_emit) o_cmd = pts_pkg::CMD_FIRE;
            end
            pts_pkg::S_EMIT: begin
                if (i_status.can_emit) o_cmd = pts_pkg::CMD_FINAL;
            end
            default: o_cmd = pts_pkg::CMD_NONE;
        endcase
    end

    // Hold the input side off while an item is in progress or in reset
    assign o_in_stall = (r_state != pts_pkg::S_IDLE) || !i_rst_n;
    assign o_state    = r_state;

endmodule

`default_nettype wire

// ===== hw/rtl/pts_dp.sv =====
// Datapath of the task scheduler: slot store, list pointers, walk cursor
// and the output register. Depends on pts_pkg; commanded by pts_ctrl.
`default_nettype none

module pts_dp #(
    parameter int ENTRIES    = pts_pkg::ENTRIES_DEF,
    parameter int PHASES     = pts_pkg::PHASES_DEF,
    parameter int TAG_BITS   = pts_pkg::TAG_BITS_DEF,
    parameter int COUNT_BITS = pts_pkg::COUNT_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  pts_pkg::t_cmd        i_cmd,
    input  pts_pkg::t_in_item    i_in_item,
    input  wire                  i_out_stall,
    output logic                 o_out_valid,
    output pts_pkg::t_out_item   o_out_item,
    output pts_pkg::t_status     o_status
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PH_W  = (PHASES > 1) ? $clog2(PHASES) : 1;
    localparam int PW    = pts_pkg::PTR_W;
    localparam logic [PW-1:0] ENT_P = PW'(ENTRIES);

    // Slot store
    logic                  r_valid [ENTRIES];
    logic [PW-1:0]         r_next  [ENTRIES];
    logic [PW-1:0]         r_prev  [ENTRIES];
    logic [PH_W-1:0]       r_sph   [ENTRIES];
    logic [TAG_BITS-1:0]   r_tag   [ENTRIES];
    logic [COUNT_BITS-1:0] r_ivl   [ENTRIES];
    logic [COUNT_BITS-1:0] r_cnt   [ENTRIES];
    logic [PW-1:0]         r_head  [PHASES];
    logic [PW-1:0]         r_tail  [PHASES];
    logic [PW-1:0]         r_free_head;

    // Item and walk registers
    pts_pkg::t_in_item r_item;
    logic [PW-1:0]     r_cur;
    logic [PW-1:0]     r_guard;
    logic [PH_W-1:0]   r_ph;
    logic [PW-1:0]     r_fp;
    logic [PW-1:0]     r_fn;
    logic [PH_W-1:0]   r_fph;
    logic [5:0]        r_rcnt;
    logic [2:0]        r_fkind;
    logic [4:0]        r_fslot;
    pts_pkg::t_out_item r_out;
    logic               r_ovalid;

    logic [IDX_W-1:0]      w_ci;
    logic                  w_rd_valid;
    logic [PW-1:0]         w_rd_next;
    logic [PW-1:0]         w_rd_prev;
    logic [PH_W-1:0]       w_rd_ph;
    logic [TAG_BITS-1:0]   w_rd_tag;
    logic [COUNT_BITS-1:0] w_rd_ivl;
    logic [COUNT_BITS-1:0] w_dec;
    logic [PH_W-1:0]       w_in_ph;
    logic                  w_ph_ok;
    logic                  w_ins_ok;
    logic                  w_live;
    logic                  w_can_emit;
    logic [PW-1:0]         w_tail;

    // Read the slot under the cursor
    assign w_ci       = r_cur[IDX_W-1:0];
    assign w_rd_valid = r_valid[w_ci];
    assign w_rd_next  = r_next[w_ci];
    assign w_rd_prev  = r_prev[w_ci];
    assign w_rd_ph    = r_sph[w_ci];
    assign w_rd_tag   = r_tag[w_ci];
    assign w_rd_ivl   = r_ivl[w_ci];
    assign w_dec      = r_cnt[w_ci] - COUNT_BITS'(1);
    assign w_tail     = r_tail[r_ph];

    assign w_in_ph    = PH_W'(r_item.phase);
    assign w_ph_ok    = 7'(r_item.phase) < 7'(PHASES);
    assign w_ins_ok   = w_ph_ok && (r_free_head < ENT_P);
    assign w_live     = (r_cur < ENT_P) && (r_guard < ENT_P);
    assign w_can_emit = !r_ovalid || !i_out_stall;

    // Status to the sequencer
    always_comb begin
        o_status.op        = r_item.op;
        o_status.ins_ok    = w_ins_ok;
        o_status.ph_ok     = w_ph_ok;
        o_status.h_ok      = (r_cur < ENT_P) && w_rd_valid;
        o_status.cur_live  = w_live;
        o_status.match     = w_live && w_rd_valid && (w_rd_tag == TAG_BITS'(r_item.tag));
        o_status.fire_zero = (w_dec == '0);
        o_status.ph_last   = (r_ph == PH_W'(PHASES - 1));
        o_status.can_emit  = w_can_emit;
        o_status.rcnt      = r_rcnt;
    end

    // Control-side store: valid bits, links, list ends, free list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_next[i]  <= (i + 1 < ENTRIES) ? PW'(i + 1) : pts_pkg::NIL;
            end
            for (int p = 0; p < PHASES; p++) begin
                r_head[p] <= pts_pkg::NIL;
                r_tail[p] <= pts_pkg::NIL;
            end
            r_free_head <= '0;
        end else begin
            case (i_cmd)
                pts_pkg::CMD_INS_A: begin
                    r_free_head   <= w_rd_next;
                    r_valid[w_ci] <= 1'b1;
                    r_next[w_ci]  <= pts_pkg::NIL;
                end
                pts_pkg::CMD_INS_B: begin
                    if (w_tail < ENT_P) begin
                        r_next[w_tail[IDX_W-1:0]] <= r_cur;
                    end else begin
                        r_head[r_ph] <= r_cur;
                    end
                    r_tail[r_ph] <= r_cur;
                end
                pts_pkg::CMD_FREE_A: begin
                    r_valid[w_ci] <= 1'b0;
                    r_next[w_ci]  <= r_free_head;
                    r_free_head   <= r_cur;
                end
                pts_pkg::CMD_FREE_B: begin
                    if (r_fp < ENT_P) begin
                        r_next[r_fp[IDX_W-1:0]] <= r_fn;
                    end else begin
                        r_head[r_fph] <= r_fn;
                    end
                    if (r_fn >= ENT_P) begin
                        r_tail[r_fph] <= r_fp;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload store: slot fields and back links
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            pts_pkg::CMD_INS_A: begin
                r_sph[w_ci]  <= r_ph;
                r_tag[w_ci]  <= TAG_BITS'(r_item.tag);
                r_ivl[w_ci]  <= COUNT_BITS'(r_item.interval);
                r_cnt[w_ci]  <= COUNT_BITS'(r_item.first_count);
                r_prev[w_ci] <= w_tail;
            end
            pts_pkg::CMD_FREE_B: begin
                if (r_fn < ENT_P) r_prev[r_fn[IDX_W-1:0]] <= r_fp;
            end
            pts_pkg::CMD_TICK: r_cnt[w_ci] <= w_dec;
            pts_pkg::CMD_FIRE: r_cnt[w_ci] <= w_rd_ivl;
            default: begin
            end
        endcase
    end

    // Item, cursor and final-result registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            pts_pkg::CMD_LOAD: r_item <= i_in_item;
            pts_pkg::CMD_START: begin
                r_rcnt  <= '0;
                r_fslot <= '0;
                r_ph    <= (r_item.op == pts_pkg::OP_REM_TAG) ? '0 : w_in_ph;
                r_cur   <= (r_item.op == pts_pkg::OP_INSERT) ? r_free_head
                                                             : PW'(r_item.handle);
                case (r_item.op)
                    pts_pkg::OP_INSERT: begin
                        r_fkind <= w_ins_ok ? pts_pkg::KIND_INSERTED : pts_pkg::KIND_FULL;
                        if (w_ins_ok) r_fslot <= 5'(r_free_head);
                    end
                    pts_pkg::OP_REM_HDL: r_fkind <= pts_pkg::KIND_NOT_FOUND;
                    pts_pkg::OP_REM_TAG: r_fkind <= pts_pkg::KIND_REMOVED;
                    default:             r_fkind <= pts_pkg::KIND_DONE;
                endcase
            end
            pts_pkg::CMD_HEAD: begin
                r_cur   <= r_head[r_ph];
                r_guard <= '0;
            end
            pts_pkg::CMD_NEXT_PH: r_ph <= r_ph + PH_W'(1);
            pts_pkg::CMD_FREE_A: begin
                r_fp    <= w_rd_prev;
                r_fn    <= w_rd_next;
                r_fph   <= w_rd_ph;
                r_rcnt  <= r_rcnt + 6'd1;
                r_fkind <= pts_pkg::KIND_REMOVED;
            end
            pts_pkg::CMD_FREE_B: begin
                r_cur   <= r_fn;
                r_guard <= r_guard + PW'(1);
            end
            pts_pkg::CMD_ADV, pts_pkg::CMD_TICK, pts_pkg::CMD_FIRE: begin
                r_cur   <= w_rd_next;
                r_guard <= r_guard + PW'(1);
            end
            default: begin
            end
        endcase
    end

    // Output register: load a beat, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd == pts_pkg::CMD_FIRE || i_cmd == pts_pkg::CMD_FINAL) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == pts_pkg::CMD_FIRE) begin
            r_out.kind          <= pts_pkg::KIND_FIRED;
            r_out.slot          <= 5'(r_cur);
            r_out.fired_tag     <= 16'(w_rd_tag);
            r_out.removed_count <= '0;
            r_out.last          <= 1'b0;
        end else if (i_cmd == pts_pkg::CMD_FINAL) begin
            r_out.kind          <= r_fkind;
            r_out.slot          <= r_fslot;
            r_out.fired_tag     <= '0;
            r_out.removed_count <= r_rcnt;
            r_out.last          <= 1'b1;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/phased_periodic_task_scheduler.sv =====
// Top level of the phased periodic task scheduler.
// Joins pts_ctrl and pts_dp; types and codes come from pts_pkg.
//
// Usage: one input channel (i_in_valid / o_in_stall / i_in_item) takes
// operation beats: insert, remove by handle, remove by tag, tick a phase.
// One output channel (o_out_valid / i_out_stall / o_out_item) returns the
// result beats of each operation, the final one flagged by last.
// One item is worked at a time; o_in_stall is high from acceptance until
// the final result is loaded into the output register.
// Steps per item: insert takes the free-list head and links it at the
// phase tail, remove by handle checks the slot and unlinks it, tick walks
// its phase list and fires each slot whose count runs out, remove by tag
// walks every phase list and frees each match, one slot at a time.
// A result waits in the output register while i_out_stall is high; the
// walk holds before the next fire or final beat until it is taken.
// Reset (synchronous, i_rst_n low) empties every phase list, links the free
// list in slot order from slot 0 and clears the output valid; no clearing
// pass is needed.
`default_nettype none

module phased_periodic_task_scheduler #(
    parameter int ENTRIES    = pts_pkg::ENTRIES_DEF,
    parameter int PHASES     = pts_pkg::PHASES_DEF,
    parameter int TAG_BITS   = pts_pkg::TAG_BITS_DEF,
    parameter int COUNT_BITS = pts_pkg::COUNT_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  pts_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output pts_pkg::t_out_item   o_out_item
);

    pts_pkg::t_cmd    w_cmd;
    pts_pkg::t_status w_status;
    pts_pkg::t_state  w_state;

    // Sequencer
    pts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall),
        .o_state    (w_state)
    );

    // Slot store and result path
    pts_dp #(
        .ENTRIES    (ENTRIES),
        .PHASES     (PHASES),
        .TAG_BITS   (TAG_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_status    (w_status)
    );

`ifndef SYNTHESIS
    // An accepted beat starts work: input is held off next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not held off after accepting a beat");

    // A new result appears only out of an item in progress
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result produced with no item in progress");

    // Removal count never exceeds the pool size once the item has started
    a_rcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_state != pts_pkg::S_IDLE) && (w_state != pts_pkg::S_START))
        |-> (w_status.rcnt <= 6'(ENTRIES)))
        else $error("removal count beyond pool size");
`endif

endmodule

`default_nettype wire
